>>> rtl/psp_pkg.sv
`default_nettype none
package psp_pkg;

   // store geometry
   localparam int MAX_REF_POINTS = 4096;
   localparam int ADDR_W         = $clog2(MAX_REF_POINTS);
   localparam int COUNT_W        = $clog2(MAX_REF_POINTS + 1);

   // field widths
   localparam int COORD_W = 32;
   localparam int LIMIT_W = 31;
   localparam int FACE_W  = 20;
   localparam int POINT_W = 3 * COORD_W;

   // distance limit after reset, about 1e-5 in Q7.24
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(168);

   // input word actions
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic do_load;
      logic do_clear;
      logic take_query;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic query_skip;
      logic scan_last;
      logic pipe_busy;
      logic hit;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/point_set_proximity_match.sv
// load, clear and ignored words leave busy low; a query keeps busy high while it
// scans the stored points, drains the compare pipeline and finishes, skipping to
// the finish when the store is empty or the face already matched; a match ends
// the scan early; one stored point is read per cycle in the scan; the result
// strobe comes in the first cycle with busy low again and cannot be held off by
// the receiver; synchronous reset empties the store, zeroes the face counter and
// sets the limit to 168; store contents are not cleared and need no clearing pass
`default_nettype none
module point_set_proximity_match (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [1:0]                   req_action,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_z,
   input  wire logic                                req_face_end,
   output logic                                     rsp_strobe,
   output logic             [psp_pkg::FACE_W-1:0]   rsp_face_index,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [psp_pkg::LIMIT_W-1:0]  csr_wdata
);

   psp_pkg::cmd_type    cmd;
   psp_pkg::status_type status;

   // limit register takes a word whenever idle
   assign csr_ready = !busy;

   // sequencer
   psp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // store, compare pipeline and counters
   psp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_face_end   (req_face_end),
      .csr_write      (csr_valid & csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_face_index (rsp_face_index)
   );

endmodule
`default_nettype wire

>>> rtl/psp_datapath.sv
`default_nettype none
module psp_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire psp_pkg::cmd_type                    cmd,
   output psp_pkg::status_type                      status,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [psp_pkg::COORD_W-1:0]  req_coord_z,
   input  wire logic                                req_face_end,
   input  wire logic                                csr_write,
   input  wire logic        [psp_pkg::LIMIT_W-1:0]  csr_wdata,
   output logic                                     rsp_strobe,
   output logic             [psp_pkg::FACE_W-1:0]   rsp_face_index
);

   localparam int CW = psp_pkg::COORD_W;
   localparam int LW = psp_pkg::LIMIT_W;
   localparam int SQ_W = 2 * LW;
   localparam int SUM_W = SQ_W + 2;

   // reference point store
   logic [psp_pkg::POINT_W-1:0] mem [psp_pkg::MAX_REF_POINTS];
   logic [psp_pkg::POINT_W-1:0] rd_data_ff;

   // control state
   logic [psp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [psp_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [psp_pkg::FACE_W-1:0]  face_ff, face_in;
   logic                        hit_ff, hit_in;
   logic                        v1_ff, v2_ff, v3_ff;
   logic                        strobe_ff, strobe_in;
   logic [LW-1:0]               limit_ff, limit_in;

   // payload registers
   logic signed [CW-1:0]        qx_ff, qy_ff, qz_ff;
   logic                        qend_ff;
   logic [SQ_W-1:0]             limit_sq_ff;
   logic [LW-1:0]               ax_ff, ay_ff, az_ff;
   logic                        near2_ff, near3_ff;
   logic [SQ_W-1:0]             sx_ff, sy_ff, sz_ff;
   logic [psp_pkg::FACE_W-1:0]  index_ff;

   logic                        store_full;
   logic [psp_pkg::COUNT_W-1:0] count_m1;
   logic signed [CW:0]          dx, dy, dz;
   logic [CW:0]                 adx, ady, adz;
   logic [CW:0]                 lim_ext;
   logic                        reject;
   logic [SUM_W-1:0]            sum_sq;
   logic                        match;

   assign store_full = (count_ff == psp_pkg::COUNT_W'(psp_pkg::MAX_REF_POINTS));
   assign count_m1   = count_ff - psp_pkg::COUNT_W'(1);

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.do_load && !store_full) begin
         mem[count_ff[psp_pkg::ADDR_W-1:0]] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // axis differences and early reject
   always_comb begin
      dx = {qx_ff[CW-1], qx_ff} - {rd_data_ff[3*CW-1], rd_data_ff[3*CW-1:2*CW]};
      dy = {qy_ff[CW-1], qy_ff} - {rd_data_ff[2*CW-1], rd_data_ff[2*CW-1:CW]};
      dz = {qz_ff[CW-1], qz_ff} - {rd_data_ff[CW-1], rd_data_ff[CW-1:0]};
      adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      adz = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);
      lim_ext = {2'b00, limit_ff};
      reject = (adx >= lim_ext) || (ady >= lim_ext) || (adz >= lim_ext);
   end

   // sum of squares against squared limit
   assign sum_sq = {2'b00, sx_ff} + {2'b00, sy_ff} + {2'b00, sz_ff};
   assign match  = v3_ff && near3_ff && (sum_sq < {2'b00, limit_sq_ff});

   // next state of control registers
   always_comb begin
      count_in  = count_ff;
      addr_in   = addr_ff;
      face_in   = face_ff;
      hit_in    = hit_ff | match;
      strobe_in = 1'b0;
      limit_in  = csr_write ? csr_wdata : limit_ff;
      if (cmd.do_load && !store_full) begin
         count_in = count_ff + psp_pkg::COUNT_W'(1);
      end
      if (cmd.do_clear) begin
         count_in = '0;
         face_in  = '0;
         hit_in   = 1'b0;
      end
      if (cmd.take_query) begin
         addr_in = '0;
      end
      if (cmd.scan) begin
         addr_in = addr_ff + psp_pkg::ADDR_W'(1);
      end
      if (cmd.finish && qend_ff) begin
         strobe_in = hit_ff;
         hit_in    = 1'b0;
         face_in   = face_ff + psp_pkg::FACE_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         addr_ff   <= '0;
         face_ff   <= '0;
         hit_ff    <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
         limit_ff  <= psp_pkg::LIMIT_RESET;
      end else begin
         count_ff  <= count_in;
         addr_ff   <= addr_in;
         face_ff   <= face_in;
         hit_ff    <= hit_in;
         v1_ff     <= cmd.scan;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= strobe_in;
         limit_ff  <= limit_in;
      end
   end

   // payload registers and compare pipeline
   always_ff @(posedge clock) begin
      if (cmd.take_query) begin
         qx_ff   <= req_coord_x;
         qy_ff   <= req_coord_y;
         qz_ff   <= req_coord_z;
         qend_ff <= req_face_end;
      end
      limit_sq_ff <= SQ_W'(limit_ff) * SQ_W'(limit_ff);
      ax_ff       <= adx[LW-1:0];
      ay_ff       <= ady[LW-1:0];
      az_ff       <= adz[LW-1:0];
      near2_ff    <= !reject;
      sx_ff       <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_ff       <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      sz_ff       <= SQ_W'(az_ff) * SQ_W'(az_ff);
      near3_ff    <= near2_ff;
      if (cmd.finish) begin
         index_ff <= face_ff;
      end
   end

   // status to controller
   always_comb begin
      status.query_skip = (count_ff == '0) || hit_ff;
      status.scan_last  = ({1'b0, addr_ff} == count_m1);
      status.pipe_busy  = v1_ff | v2_ff | v3_ff;
      status.hit        = hit_ff;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_face_index = index_ff;

endmodule
`default_nettype wire

>>> rtl/psp_ctrl.sv
`default_nettype none
module psp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_action,
   input  wire psp_pkg::status_type status,
   output psp_pkg::cmd_type         cmd,
   output logic                     busy
);

   psp_pkg::state_type state_ff, state_in;
   psp_pkg::action_type action;

   assign action = psp_pkg::action_type'(req_action);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         psp_pkg::ST_IDLE: begin
            if (start) begin
               unique case (action)
                  psp_pkg::ACT_LOAD: begin
                     cmd.do_load = 1'b1;
                  end
                  psp_pkg::ACT_QUERY: begin
                     cmd.take_query = 1'b1;
                     state_in = status.query_skip ? psp_pkg::ST_FINISH : psp_pkg::ST_SCAN;
                  end
                  psp_pkg::ACT_CLEAR: begin
                     cmd.do_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         psp_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last || status.hit) begin
               state_in = psp_pkg::ST_DRAIN;
            end
         end
         psp_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = psp_pkg::ST_FINISH;
            end
         end
         psp_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = psp_pkg::ST_IDLE;
         end
         default: begin
            state_in = psp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != psp_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> tb/face_match_checker.sv
`default_nettype none
module face_match_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               busy,
   input  wire logic        [1:0]                  req_action,
   input  wire logic signed [psp_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [psp_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [psp_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic                               req_face_end,
   input  wire logic                               rsp_strobe,
   input  wire logic        [psp_pkg::FACE_W-1:0]  rsp_face_index,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic        [psp_pkg::LIMIT_W-1:0] csr_wdata,
   output int                                      fail_count,
   output int                                      pending
);

   // predicted copy of the point store and face tracking
   logic signed [psp_pkg::COORD_W-1:0] stored_x [psp_pkg::MAX_REF_POINTS];
   logic signed [psp_pkg::COORD_W-1:0] stored_y [psp_pkg::MAX_REF_POINTS];
   logic signed [psp_pkg::COORD_W-1:0] stored_z [psp_pkg::MAX_REF_POINTS];
   int                                 stored_count;
   logic                               face_matched;
   logic        [psp_pkg::FACE_W-1:0]  face_number;
   logic        [psp_pkg::LIMIT_W-1:0] radius;
   logic        [psp_pkg::FACE_W-1:0]  face_index_due [$];
   logic        [psp_pkg::FACE_W-1:0]  oldest_index;

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // absolute axis difference, exact in 33 bits
   function automatic logic [32:0] axis_gap(input logic signed [psp_pkg::COORD_W-1:0] a,
                                            input logic signed [psp_pkg::COORD_W-1:0] b);
      logic signed [32:0] d;
      d = {a[psp_pkg::COORD_W-1], a} - {b[psp_pkg::COORD_W-1], b};
      return d[32] ? 33'(-d) : 33'(d);
   endfunction

   // early reject per axis, then exact squared distance against squared radius
   function automatic bit within_radius(input int idx,
                                        input logic signed [psp_pkg::COORD_W-1:0] x,
                                        input logic signed [psp_pkg::COORD_W-1:0] y,
                                        input logic signed [psp_pkg::COORD_W-1:0] z);
      logic [32:0] dx;
      logic [32:0] dy;
      logic [32:0] dz;
      logic [63:0] span;
      logic [63:0] reach;
      dx = axis_gap(x, stored_x[idx]);
      dy = axis_gap(y, stored_y[idx]);
      dz = axis_gap(z, stored_z[idx]);
      if (dx >= 33'(radius) || dy >= 33'(radius) || dz >= 33'(radius))
         return 1'b0;
      span  = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy) + 64'(dz) * 64'(dz);
      reach = 64'(radius) * 64'(radius);
      return span < reach;
   endfunction

   // effect of one accepted input word
   task automatic apply_word();
      case (psp_pkg::action_type'(req_action))
         psp_pkg::ACT_LOAD: begin
            // a full store drops the load
            if (stored_count < psp_pkg::MAX_REF_POINTS) begin
               stored_x[stored_count] = req_coord_x;
               stored_y[stored_count] = req_coord_y;
               stored_z[stored_count] = req_coord_z;
               stored_count++;
            end
         end
         psp_pkg::ACT_QUERY: begin
            for (int i = 0; i < stored_count && !face_matched; i++) begin
               if (within_radius(i, req_coord_x, req_coord_y, req_coord_z))
                  face_matched = 1'b1;
            end
            if (req_face_end) begin
               if (face_matched)
                  face_index_due = {face_index_due, face_number};
               face_matched = 1'b0;
               face_number  = face_number + psp_pkg::FACE_W'(1);
            end
         end
         psp_pkg::ACT_CLEAR: begin
            stored_count = 0;
            face_number  = '0;
            face_matched = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         face_matched = 1'b0;
         face_number  = '0;
         radius       = psp_pkg::LIMIT_RESET;
         face_index_due.delete();
      end else begin
         // result word against the oldest due face index
         if (rsp_strobe) begin
            if (face_index_due.size() == 0) begin
               flag_mismatch($sformatf("face index %0d with none due", rsp_face_index));
            end else begin
               oldest_index = face_index_due.pop_front();
               if (rsp_face_index !== oldest_index)
                  flag_mismatch($sformatf("face index %0d, due %0d",
                                          rsp_face_index, oldest_index));
            end
         end
         // radius register write
         if (csr_valid && csr_ready)
            radius = csr_wdata;
         // input word
         if (start && !busy)
            apply_word();
      end
      pending = face_index_due.size();
   end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;

   localparam int QUIET_LIMIT    = 25000;
   localparam int HOLD_CYCLES    = 8;
   localparam int RANDOM_WORDS   = 114;
   localparam int SMALL_STORE    = 24;
   localparam logic signed [psp_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [psp_pkg::COORD_W-1:0] COORD_MIN = 32'sh80000000;
   localparam logic        [psp_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

   logic                               clock        = 1'b0;
   logic                               reset        = 1'b1;
   logic                               start        = 1'b0;
   logic                               busy;
   logic        [1:0]                  req_action   = psp_pkg::ACT_LOAD;
   logic signed [psp_pkg::COORD_W-1:0] req_coord_x  = '0;
   logic signed [psp_pkg::COORD_W-1:0] req_coord_y  = '0;
   logic signed [psp_pkg::COORD_W-1:0] req_coord_z  = '0;
   logic                               req_face_end = 1'b0;
   logic                               rsp_strobe;
   logic        [psp_pkg::FACE_W-1:0]  rsp_face_index;
   logic                               csr_valid    = 1'b0;
   logic                               csr_ready;
   logic        [psp_pkg::LIMIT_W-1:0] csr_wdata    = '0;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int random_words = 0;
   bit steady       = 1'b0;

   // points the store holds, used to aim queries
   logic signed [psp_pkg::COORD_W-1:0] held_x [$];
   logic signed [psp_pkg::COORD_W-1:0] held_y [$];
   logic signed [psp_pkg::COORD_W-1:0] held_z [$];
   logic        [psp_pkg::LIMIT_W-1:0] aim_limit = psp_pkg::LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_set_proximity_match i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_face_end   (req_face_end),
      .rsp_strobe     (rsp_strobe),
      .rsp_face_index (rsp_face_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   face_match_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_face_end   (req_face_end),
      .rsp_strobe     (rsp_strobe),
      .rsp_face_index (rsp_face_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** point_set_proximity_match: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offset a coordinate by less than half the radius
   function automatic logic signed [psp_pkg::COORD_W-1:0] nudge(
      input logic signed [psp_pkg::COORD_W-1:0] c);
      logic        [psp_pkg::LIMIT_W-1:0] half;
      logic signed [psp_pkg::COORD_W-1:0] step;
      half = aim_limit >> 1;
      if (half == 0)
         return c;
      step = $urandom_range(0, half - 1);
      return $urandom_range(0, 1) ? c + step : c - step;
   endfunction

   // present one word and hold it until accepted
   task automatic send_word(input psp_pkg::action_type act,
                            input logic signed [psp_pkg::COORD_W-1:0] x,
                            input logic signed [psp_pkg::COORD_W-1:0] y,
                            input logic signed [psp_pkg::COORD_W-1:0] z,
                            input logic last);
      @(negedge clock);
      start        = 1'b1;
      req_action   = act;
      req_coord_x  = x;
      req_coord_y  = y;
      req_coord_z  = z;
      req_face_end = last;
      do @(posedge clock); while (busy);
      if (act == psp_pkg::ACT_LOAD && held_x.size() < psp_pkg::MAX_REF_POINTS) begin
         held_x = {held_x, x};
         held_y = {held_y, y};
         held_z = {held_z, z};
      end else if (act == psp_pkg::ACT_CLEAR) begin
         held_x.delete();
         held_y.delete();
         held_z.delete();
      end
   endtask

   // idle cycles with junk on the payload
   task automatic idle_gap();
      repeat (gap_len()) begin
         @(negedge clock);
         start        = 1'b0;
         req_action   = 2'($urandom_range(0, 3));
         req_coord_x  = $urandom;
         req_coord_y  = $urandom;
         req_coord_z  = $urandom;
         req_face_end = 1'($urandom_range(0, 1));
      end
   endtask

   task automatic word_then_gap(input psp_pkg::action_type act,
                                input logic signed [psp_pkg::COORD_W-1:0] x,
                                input logic signed [psp_pkg::COORD_W-1:0] y,
                                input logic signed [psp_pkg::COORD_W-1:0] z,
                                input logic last);
      send_word(act, x, y, z, last);
      idle_gap();
   endtask

   // drop start, wait for all due results and for the block to go quiet
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (HOLD_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [psp_pkg::LIMIT_W-1:0] value);
      settle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_wdata = psp_pkg::LIMIT_W'($urandom);
      aim_limit = value;
   endtask

   // query face of one to four vertices, aimed at stored points most of the time
   task automatic random_face();
      int                                 n;
      int                                 pick;
      int                                 idx;
      logic signed [psp_pkg::COORD_W-1:0] x;
      logic signed [psp_pkg::COORD_W-1:0] y;
      logic signed [psp_pkg::COORD_W-1:0] z;
      logic                               last;
      n = $urandom_range(1, 4);
      for (int v = 0; v < n; v++) begin
         pick = $urandom_range(0, 99);
         if (held_x.size() > 0 && pick < 65) begin
            idx = $urandom_range(0, held_x.size() - 1);
            x   = held_x[idx];
            y   = held_y[idx];
            z   = held_z[idx];
            if (pick >= 15) begin
               x = nudge(x);
               y = nudge(y);
               z = nudge(z);
            end
         end else begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end
         // a broken face now and then: no end mark, so it runs into the next
         last = (v == n - 1) && ($urandom_range(0, 9) != 0);
         word_then_gap(psp_pkg::ACT_QUERY, x, y, z, last);
         random_words++;
      end
   endtask

   task automatic random_burst(input int words);
      int                                 stop;
      int                                 r;
      int                                 idx;
      logic signed [psp_pkg::COORD_W-1:0] x;
      logic signed [psp_pkg::COORD_W-1:0] y;
      logic signed [psp_pkg::COORD_W-1:0] z;
      stop = random_words + words;
      while (random_words < stop) begin
         r = $urandom_range(0, 99);
         if (r < 7) begin
            word_then_gap(psp_pkg::ACT_CLEAR, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            random_words++;
         end else if (r < 12) begin
            word_then_gap(psp_pkg::ACT_NONE, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            random_words++;
         end else if (r < 35 && held_x.size() < SMALL_STORE) begin
            if (held_x.size() > 0 && $urandom_range(0, 9) < 3) begin
               idx = $urandom_range(0, held_x.size() - 1);
               x   = nudge(held_x[idx]);
               y   = nudge(held_y[idx]);
               z   = nudge(held_z[idx]);
            end else begin
               x = $urandom;
               y = $urandom;
               z = $urandom;
            end
            word_then_gap(psp_pkg::ACT_LOAD, x, y, z, 1'($urandom_range(0, 1)));
            random_words++;
         end else begin
            random_face();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset radius of 168: empty store, axis and squared-distance edges
      word_then_gap(psp_pkg::ACT_QUERY, 0, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_LOAD, 0, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      word_then_gap(psp_pkg::ACT_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      word_then_gap(psp_pkg::ACT_QUERY, 0, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 167, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 0, -168, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 100, 100, -100, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 96, -96, 96, 1'b1);
      // face of three vertices, only the middle one near
      word_then_gap(psp_pkg::ACT_QUERY, COORD_MAX, COORD_MIN, 5, 1'b0);
      word_then_gap(psp_pkg::ACT_QUERY, COORD_MIN + 100, COORD_MIN, COORD_MIN, 1'b0);
      word_then_gap(psp_pkg::ACT_QUERY, $urandom, $urandom, $urandom, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, COORD_MAX - 167, COORD_MAX, COORD_MAX, 1'b1);
      word_then_gap(psp_pkg::ACT_NONE, $urandom, $urandom, $urandom, 1'b1);
      word_then_gap(psp_pkg::ACT_LOAD, $urandom, $urandom, $urandom, 1'b1);
      word_then_gap(psp_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 0, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_LOAD, 5, 5, 5, 1'b0);
      word_then_gap(psp_pkg::ACT_QUERY, 5, 5, 5, 1'b1);

      // zero radius matches nothing
      write_limit('0);
      word_then_gap(psp_pkg::ACT_QUERY, 5, 5, 5, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 6, 5, 5, 1'b1);

      // widest radius against the widest differences
      write_limit(LIMIT_MAX);
      word_then_gap(psp_pkg::ACT_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, 5, 5, 5, 1'b1);
      word_then_gap(psp_pkg::ACT_LOAD, COORD_MIN, 0, 0, 1'b0);
      word_then_gap(psp_pkg::ACT_QUERY, COORD_MAX, 0, 0, 1'b1);
      word_then_gap(psp_pkg::ACT_QUERY, $urandom, $urandom, $urandom, 1'b1);

      // random phases over a spread of radii
      for (int p = 0; p < 60 && random_words < RANDOM_WORDS; p++) begin
         case (p % 5)
            0: write_limit(psp_pkg::LIMIT_W'(1));
            1: write_limit(psp_pkg::LIMIT_W'($urandom_range(2, 4096)));
            2: write_limit(psp_pkg::LIMIT_RESET);
            3: write_limit(psp_pkg::LIMIT_W'($urandom >> 1));
            default: write_limit(LIMIT_MAX);
         endcase
         steady = ($urandom_range(0, 3) == 0);
         random_burst(30);
      end

      settle();
      if (fail_count == 0)
         $display("** point_set_proximity_match: PASSED **");
      else
         $display("** point_set_proximity_match: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
rtl/psp_pkg.sv
rtl/psp_datapath.sv
rtl/psp_ctrl.sv
rtl/point_set_proximity_match.sv
tb/face_match_checker.sv
tb/testbench.sv
